### rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants of the LED matrix segment scanner.
// ----------------------------------------------------------------------------
package lms_pkg;

    // Geometry of the segment store.
    localparam int SEGMENT_COUNT    = 4;
    localparam int ROWS_PER_SEGMENT = 7;
    localparam int COLS_PER_SEGMENT = 8;
    localparam int PIXEL_SHIFT      = 3;
    localparam int PIXEL_W          = COLS_PER_SEGMENT - PIXEL_SHIFT;
    localparam int COLUMN_W         = 32;
    localparam int COLUMN_SEGS      = (SEGMENT_COUNT < COLUMN_W / COLS_PER_SEGMENT) ?
                                      SEGMENT_COUNT : COLUMN_W / COLS_PER_SEGMENT;

    localparam logic [2:0] LAST_ROW = 3'd7;

    // Command codes.
    localparam logic [2:0] CMD_WRITE       = 3'd0;
    localparam logic [2:0] CMD_SHIFT_RIGHT = 3'd1;
    localparam logic [2:0] CMD_SHIFT_LEFT  = 3'd2;
    localparam logic [2:0] CMD_SCAN        = 3'd3;
    localparam logic [2:0] CMD_ROW_RESET   = 3'd4;

    // Fixed values of scan and row reset results.
    localparam logic [7:0] ROW_RESET_PATTERN = 8'h80;
    localparam logic [3:0] ROW_COUNT_SCAN    = 4'd1;
    localparam logic [3:0] ROW_COUNT_RESET   = 4'd8;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_DOUBLE_DOT = 3'd0;

    typedef struct packed {
        logic [2:0]                                  command;
        logic [2:0]                                  segment;
        logic [2:0]                                  shift_amount;
        logic [ROWS_PER_SEGMENT-1:0][PIXEL_W-1:0]    pixels;
    } item_t;

    typedef struct packed {
        logic [2:0]          active_row;
        logic                latch;
        logic                column_valid;
        logic [COLUMN_W-1:0] column_bits;
        logic [3:0]          row_bit_count;
        logic [7:0]          row_bits;
    } result_t;

endpackage

### rtl/led_matrix_segment_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_segment_scanner
// Multiplexed LED matrix scan controller with a segment store, shifts,
// row scanning and an APB register for the double dot.
// ----------------------------------------------------------------------------
// The block takes one command transaction per clock cycle. Each transaction
// is captured in an input register, processed in a single pass of short logic
// (store write or shift, or a row step), and a scan or row-reset command
// places its result in the output register as it leaves the input register.
// Writes and shifts give no result. The rate of one transaction per cycle is
// held as long as the output side takes results; when m_tready is low with a
// result waiting and the command in the input register also gives a result,
// the input register holds and s_tready drops, so the only thing that slows
// the block is back-pressure on the result channel. The segment store and
// row counter clear at reset, and the double dot register may be written at
// any time the block is idle.
module led_matrix_segment_scanner
    import lms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Command channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tuser: command[2:0]
    input  logic [2:0]  s_tuser,
    // tdata: segment[2:0], shift_amount[5:3], pixels_row0[10:6],
    //        pixels_row1[15:11], pixels_row2[20:16], pixels_row3[25:21],
    //        pixels_row4[30:26], pixels_row5[35:31], pixels_row6[40:36], zero pad
    input  logic [47:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: row_bits[7:0], row_bit_count[11:8], column_bits[43:12],
    //        column_valid[44], latch[45], active_row[48:46], zero pad
    output logic [55:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register.
    logic double_dot_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DOUBLE_DOT) ? {31'd0, double_dot_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_dot_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_DOUBLE_DOT))
        begin
            double_dot_reg <= pwdata[0];
        end
    end

    // Input register: unpack the transaction into the item layout.
    item_t in_item;
    item_t s1_item_reg;
    logic  s1_valid_reg;

    always_comb
    begin
        in_item.command      = s_tuser;
        in_item.segment      = s_tdata[2:0];
        in_item.shift_amount = s_tdata[5:3];
        for (int r = 0; r < ROWS_PER_SEGMENT; r++)
        begin
            in_item.pixels[r] = s_tdata[6 + r*PIXEL_W +: PIXEL_W];
        end
    end

    // A command moves out of the input register when it gives no result, or
    // when the output register is empty or being emptied this cycle.
    logic    has_result;
    logic    out_free;
    logic    s1_fire;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t scan_result;
    logic [2:0]          rd_row;
    logic [COLUMN_W-1:0] column_word;

    assign has_result = (s1_item_reg.command == CMD_SCAN) ||
                        (s1_item_reg.command == CMD_ROW_RESET);
    assign out_free   = !out_valid_reg || m_tready;
    assign s1_fire    = s1_valid_reg && (!has_result || out_free);
    assign s_tready   = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_item_reg <= in_item;
        end
    end

    lms_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .item        (s1_item_reg),
        .rd_row      (rd_row),
        .column_word (column_word)
    );

    lms_scan u_scan (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (s1_fire),
        .command           (s1_item_reg.command),
        .double_dot_enable (double_dot_reg),
        .column_word       (column_word),
        .rd_row            (rd_row),
        .result            (scan_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_res_reg <= scan_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    // A waiting result that is not taken blocks a result-giving command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && has_result && out_valid_reg && !m_tready)
        |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("result-giving command left the input register while blocked");

    // Column data is only marked valid on rows other than row seven.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.column_valid) |-> (out_res_reg.active_row != LAST_ROW))
        else $error("column word marked valid on row seven");

    // Without valid columns the column word is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.column_valid) |-> (out_res_reg.column_bits == '0))
        else $error("column word not cleared when not valid");

    // A row reset result always reports row zero with the row reset pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.row_bit_count == ROW_COUNT_RESET))
        |-> ((out_res_reg.active_row == 3'd0) && (out_res_reg.row_bits == ROW_RESET_PATTERN)))
        else $error("row reset result malformed");

endmodule

### rtl/lms_store.sv
// ----------------------------------------------------------------------------
// lms_store
// Segment store: whole-segment writes, shifts by whole segments, and a
// column word read for one row.
// ----------------------------------------------------------------------------
module lms_store
    import lms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  item_t               item,
    input  logic [2:0]          rd_row,
    output logic [COLUMN_W-1:0] column_word
);

    // Only the five pixel bits are kept; bits 0..2 of each row byte are zero.
    logic [PIXEL_W-1:0] store_reg  [SEGMENT_COUNT][ROWS_PER_SEGMENT];
    logic [PIXEL_W-1:0] store_next [SEGMENT_COUNT][ROWS_PER_SEGMENT];

    always_comb
    begin
        for (int i = 0; i < SEGMENT_COUNT; i++)
        begin
            for (int r = 0; r < ROWS_PER_SEGMENT; r++)
            begin
                store_next[i][r] = store_reg[i][r];
            end
        end
        case (item.command)
            CMD_WRITE:
            begin
                for (int i = 0; i < SEGMENT_COUNT; i++)
                begin
                    if (32'(item.segment) == i)
                    begin
                        for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                        begin
                            store_next[i][r] = item.pixels[r];
                        end
                    end
                end
            end
            CMD_SHIFT_RIGHT:
            begin
                // Shifts of zero or of the whole store leave it unchanged.
                for (int k = 1; k < SEGMENT_COUNT; k++)
                begin
                    if (32'(item.shift_amount) == k)
                    begin
                        for (int i = k; i < SEGMENT_COUNT; i++)
                        begin
                            for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                            begin
                                store_next[i][r] = store_reg[i-k][r];
                            end
                        end
                    end
                end
            end
            CMD_SHIFT_LEFT:
            begin
                for (int k = 1; k < SEGMENT_COUNT; k++)
                begin
                    if (32'(item.shift_amount) == k)
                    begin
                        for (int i = 0; i + k < SEGMENT_COUNT; i++)
                        begin
                            for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                            begin
                                store_next[i][r] = store_reg[i+k][r];
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEGMENT_COUNT; i++)
            begin
                for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                begin
                    store_reg[i][r] <= '0;
                end
            end
        end
        else if (fire)
        begin
            store_reg <= store_next;
        end
    end

    // Column word: segment s fills bits s*8 .. s*8+7; segments beyond the word
    // are dropped, and row seven reads as zero.
    always_comb
    begin
        column_word = '0;
        for (int s = 0; s < COLUMN_SEGS; s++)
        begin
            for (int r = 0; r < ROWS_PER_SEGMENT; r++)
            begin
                if (32'(rd_row) == r)
                begin
                    column_word[s*COLS_PER_SEGMENT +: COLS_PER_SEGMENT] =
                        {store_reg[s][r], PIXEL_SHIFT'(0)};
                end
            end
        end
    end

endmodule

### rtl/lms_scan.sv
// ----------------------------------------------------------------------------
// lms_scan
// Row counter and result formatting for scan steps and row resets.
// ----------------------------------------------------------------------------
module lms_scan
    import lms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [2:0]          command,
    input  logic                double_dot_enable,
    input  logic [COLUMN_W-1:0] column_word,
    output logic [2:0]          rd_row,
    output result_t             result
);

    logic [2:0] row_reg;
    logic [2:0] row_next;

    assign rd_row = row_reg + 3'd1;

    always_comb
    begin
        row_next = row_reg;
        result   = '0;
        case (command)
            CMD_SCAN:
            begin
                row_next             = rd_row;
                result.row_bits      = {7'd0, (rd_row == 3'd0)};
                result.row_bit_count = ROW_COUNT_SCAN;
                result.active_row    = rd_row;
                if (rd_row == LAST_ROW)
                begin
                    result.latch = double_dot_enable;
                end
                else
                begin
                    result.column_bits  = column_word;
                    result.column_valid = 1'b1;
                    result.latch        = 1'b1;
                end
            end
            CMD_ROW_RESET:
            begin
                row_next             = 3'd0;
                result.row_bits      = ROW_RESET_PATTERN;
                result.row_bit_count = ROW_COUNT_RESET;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 3'd0;
        end
        else if (fire)
        begin
            row_reg <= row_next;
        end
    end

endmodule

### verif/lms_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_scan_checker
// Watches the command, result and register channels of the LED matrix
// segment scanner, keeps its own copy of the segment store, row counter and
// double dot setting, and compares every result transaction with the result
// it predicts for the oldest scan or row reset still waiting.
// ----------------------------------------------------------------------------
module lms_scan_checker
    import lms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [2:0]  s_tuser,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          bad_results,
    output int          rows_outstanding
);

    logic [7:0] seg_rows [SEGMENT_COUNT][ROWS_PER_SEGMENT];
    logic [2:0] row_ptr;
    logic       double_dot;
    result_t    rows_due[$];
    int         failures;

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Updates the model for one accepted command and queues the result that
    // a scan or a row reset must produce.
    task automatic apply_command(input logic [2:0] cmd, input logic [47:0] fields);
        logic [2:0] seg;
        logic [2:0] amt;
        result_t    res;
        seg = fields[2:0];
        amt = fields[5:3];
        res = '0;
        case (cmd)
            CMD_WRITE:
                if (seg < SEGMENT_COUNT)
                    for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                        seg_rows[seg][r] = {fields[6 + PIXEL_W*r +: PIXEL_W],
                                            {PIXEL_SHIFT{1'b0}}};
            CMD_SHIFT_RIGHT:
                // Walking down from the top lets the copy run in place; the
                // lowest segments keep what they held before.
                if (amt != 0 && amt < SEGMENT_COUNT)
                    for (int s = SEGMENT_COUNT - 1; s >= amt; s--)
                        for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                            seg_rows[s][r] = seg_rows[s - amt][r];
            CMD_SHIFT_LEFT:
                if (amt != 0 && amt < SEGMENT_COUNT)
                    for (int s = amt; s < SEGMENT_COUNT; s++)
                        for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                            seg_rows[s - amt][r] = seg_rows[s][r];
            CMD_SCAN:
            begin
                row_ptr = row_ptr + 3'd1;
                res.row_bits      = (row_ptr == 3'd0) ? 8'd1 : 8'd0;
                res.row_bit_count = ROW_COUNT_SCAN;
                res.active_row    = row_ptr;
                if (row_ptr == LAST_ROW)
                begin
                    res.latch = double_dot;
                end
                else
                begin
                    for (int s = 0; s < COLUMN_SEGS; s++)
                        res.column_bits[s*COLS_PER_SEGMENT +: COLS_PER_SEGMENT] =
                            seg_rows[s][row_ptr];
                    res.column_valid = 1'b1;
                    res.latch        = 1'b1;
                end
                rows_due.push_back(res);
            end
            CMD_ROW_RESET:
            begin
                row_ptr           = 3'd0;
                res.row_bits      = ROW_RESET_PATTERN;
                res.row_bit_count = ROW_COUNT_RESET;
                rows_due.push_back(res);
            end
            default:
                ;
        endcase
    endtask

    task automatic check_row_word(input logic [55:0] word);
        result_t want;
        if (rows_due.size() == 0)
        begin
            note_failure($sformatf("unexpected result tdata=%h", word));
        end
        else
        begin
            want = rows_due.pop_front();
            if (word[7:0]   !== want.row_bits      ||
                word[11:8]  !== want.row_bit_count ||
                word[43:12] !== want.column_bits   ||
                word[44]    !== want.column_valid  ||
                word[45]    !== want.latch         ||
                word[48:46] !== want.active_row)
                note_failure($sformatf(
                    {"row_bits %h/%h count %0d/%0d columns %h/%h ",
                     "col_valid %b/%b latch %b/%b row %0d/%0d (expected/actual)"},
                    want.row_bits, word[7:0], want.row_bit_count, word[11:8],
                    want.column_bits, word[43:12], want.column_valid, word[44],
                    want.latch, word[45], want.active_row, word[48:46]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SEGMENT_COUNT; s++)
                for (int r = 0; r < ROWS_PER_SEGMENT; r++)
                    seg_rows[s][r] = 8'd0;
            row_ptr    = 3'd0;
            double_dot = 1'b0;
            failures   = 0;
            rows_due.delete();
        end
        else
        begin
            // Results leave only after passing the input and output registers, so popping
            // before pushing never pairs a result with a command of the same edge.
            if (m_tvalid && m_tready)
                check_row_word(m_tdata);
            if (psel && penable && pready && paddr == ADDR_DOUBLE_DOT)
            begin
                if (pwrite)
                    double_dot = pwdata[0];
                else if (prdata !== {31'd0, double_dot})
                    note_failure($sformatf("register read %h, expected %h",
                                           prdata, {31'd0, double_dot}));
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata);
        end
        bad_results      <= failures;
        rows_outstanding <= rows_due.size();
    end

endmodule

### verif/tb_led_matrix_segment_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_segment_scanner
// Drives command transactions and register writes into the LED matrix
// segment scanner under changing back-pressure; the checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_led_matrix_segment_scanner;
    import lms_pkg::*;

    // A long receiver hold-off plus random gaps must never reach this many
    // cycles without any transaction on either channel.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    // Covers writes and shifts still in flight when the last result arrives.
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 330;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // tuser: command[2:0]
    logic [2:0]  s_tuser;
    // tdata: segment[2:0], shift_amount[5:3], pixels_row0..6[40:6], zero pad
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: row_bits[7:0], row_bit_count[11:8], column_bits[43:12],
    //        column_valid[44], latch[45], active_row[48:46], zero pad
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int bad_results;
    int rows_outstanding;

    // Idle percentages of the two sides, changed between phases.
    int tx_idle_pct;
    int rx_idle_pct;
    // The receiver process serves each new hold request with one long stall.
    int hold_requests;
    int holds_served;
    int hold_left;
    int stalled_cycles;

    led_matrix_segment_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lms_scan_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tuser          (s_tuser),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .bad_results      (bad_results),
        .rows_outstanding (rows_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls at the current percentage, or a long hold-off
    // whenever the stimulus asks for one. It keeps its own count of the hold.
    initial
    begin
        m_tready     <= 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: counts cycles without any transaction and ends a hung run.
    initial
    begin
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one command transaction and returns at the edge that accepted it.
    // The sender may idle first; valid is only lowered in a step where it is
    // not also raised.
    task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] seg,
                            input logic [2:0] amt, input logic [34:0] pix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, pix, amt, seg};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops offering commands until every predicted result has been taken,
    // then lets writes and shifts still inside the block finish.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rows_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the double dot register and reads it back; the read value is
    // checked by the checker.
    task automatic program_double_dot(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DOUBLE_DOT;
        pwdata  <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random command mix. Scans dominate so that the row counter wraps often;
    // writes mostly hit real segments and shifts mostly use useful amounts,
    // with out-of-range values and unknown commands mixed in as noise.
    task automatic run_random(input int count, input bit with_pressure);
        int          pick;
        logic [2:0]  cmd;
        logic [2:0]  seg;
        logic [2:0]  amt;
        logic [34:0] pix;
        for (int i = 0; i < count; i++)
        begin
            if (with_pressure && i == count / 3)
                hold_requests <= hold_requests + 1;
            if (with_pressure && i == 2 * count / 3)
                drain_results();
            pick = $urandom_range(99);
            seg  = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                            : 3'($urandom_range(SEGMENT_COUNT - 1));
            amt  = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                            : 3'($urandom_range(SEGMENT_COUNT - 1, 1));
            pix  = 35'({$urandom, $urandom});
            if (pick < 30)
                cmd = CMD_WRITE;
            else if (pick < 42)
                cmd = CMD_SHIFT_RIGHT;
            else if (pick < 54)
                cmd = CMD_SHIFT_LEFT;
            else if (pick < 90)
                cmd = CMD_SCAN;
            else if (pick < 96)
                cmd = CMD_ROW_RESET;
            else
                cmd = 3'($urandom_range(7, 5));
            send_cmd(cmd, seg, amt, pix);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tuser       <= CMD_WRITE;
        s_tdata       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_DOUBLE_DOT;
        pwdata        <= '0;
        hold_requests <= 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the double dot off: full and empty pixels, a
        // walking pattern, writes to segments that do not exist, a full row
        // cycle through row seven and the wrap, shifts by zero, by the
        // segment count and beyond, a row reset and unknown commands.
        program_double_dot(1'b0);
        send_cmd(CMD_WRITE, 3'd0, 3'd0, {7{5'd31}});
        send_cmd(CMD_WRITE, 3'd1, 3'd0, {5'h15, 5'h0a, 5'h15, 5'h0a, 5'h15, 5'h0a, 5'h15});
        send_cmd(CMD_WRITE, 3'd3, 3'd0, {5'd0, 5'd31, 5'd16, 5'd8, 5'd4, 5'd2, 5'd1});
        send_cmd(CMD_WRITE, 3'd4, 3'd0, {7{5'd31}});
        send_cmd(CMD_WRITE, 3'd7, 3'd7, {7{5'd31}});
        for (int i = 0; i < 8; i++)
            send_cmd(CMD_SCAN, 3'd0, 3'd0, '0);
        send_cmd(CMD_SHIFT_RIGHT, 3'd0, 3'd1, '0);
        send_cmd(CMD_SCAN, 3'd0, 3'd0, '0);
        send_cmd(CMD_SHIFT_LEFT, 3'd0, 3'd2, '0);
        send_cmd(CMD_SCAN, 3'd0, 3'd0, '0);
        send_cmd(CMD_SHIFT_RIGHT, 3'd0, 3'd0, '0);
        send_cmd(CMD_SHIFT_LEFT, 3'd0, 3'd4, '0);
        send_cmd(CMD_SHIFT_RIGHT, 3'd7, 3'd7, {7{5'd31}});
        send_cmd(CMD_SCAN, 3'd0, 3'd0, '0);
        send_cmd(CMD_ROW_RESET, 3'd0, 3'd0, '0);
        send_cmd(3'd5, 3'd7, 3'd7, {7{5'd31}});
        send_cmd(3'd7, 3'd7, 3'd7, {7{5'd31}});
        send_cmd(CMD_SCAN, 3'd0, 3'd0, '0);
        drain_results();

        // Sender idles lightly while the receiver stalls most of the time.
        program_double_dot(1'b1);
        tx_idle_pct = 20;
        rx_idle_pct = 71;
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        // The other way round: a sparse sender and a mostly ready receiver.
        program_double_dot(1'b0);
        tx_idle_pct = 71;
        rx_idle_pct = 20;
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        // Full rate on both sides, with one long receiver hold-off that fills
        // the block and one sender pause until all results are back.
        program_double_dot(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b1);
        drain_results();

        if (bad_results == 0 && rows_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/lms_pkg.sv
rtl/lms_store.sv
rtl/lms_scan.sv
rtl/led_matrix_segment_scanner.sv
verif/lms_scan_checker.sv
verif/tb_led_matrix_segment_scanner.sv
